// ===== src/amsb_pkg.sv =====
// Shared types and constants of the AMSBound parameter update block.
// No dependencies; the other files, apart from amsb_divsqrt, refer to it by scoped names.
package amsb_pkg;

	localparam logic [24:0] ONE_Q = 25'h1000000;
	localparam logic [31:0] MAX_Q = 32'h7FFFFFFF;

	typedef enum logic [2:0] {
		CFG_LEARNING_RATE = 3'd0,
		CFG_FIRST_DECAY   = 3'd1,
		CFG_SECOND_DECAY  = 3'd2,
		CFG_TARGET_RATE   = 3'd3,
		CFG_BOUND_SPEED   = 3'd4,
		CFG_EPSILON       = 3'd5,
		CFG_DECAY_WEIGHT  = 3'd6
	} cfg_idx_t;

	// decay factors are already limited to one
	typedef struct packed {
		logic [30:0] lr;
		logic [24:0] b1;
		logic [24:0] b2;
		logic [30:0] fin;
		logic [30:0] gam;
		logic [30:0] eps;
		logic [30:0] wd;
	} cfg_t;

	typedef struct packed {
		logic [11:0]        idx;
		logic signed [31:0] param;
		logic signed [31:0] grad;
		logic [31:0]        step;
		logic [24:0]        bc1;
		logic [24:0]        bc2;
		logic               bypass;
	} item_t;

endpackage

// ===== src/amsb_divsqrt.sv =====
// Bit-serial unit: unsigned 64/64 restoring divide or integer square root.
// Uses no package items; one quotient or root bit per cycle.
module amsb_divsqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        sqrt_mode,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        busy,
	output logic        done,
	output logic [63:0] res
);

	localparam logic [6:0] DIV_STEPS  = 7'd64;
	localparam logic [6:0] SQRT_STEPS = 7'd28;

	logic [6:0]  cnt_q;
	logic        done_q;
	logic        mode_q;
	logic [63:0] rem_q;
	logic [63:0] nq_q;
	logic [63:0] den_q;
	logic [55:0] sx_q;
	logic [55:0] root_q;
	logic [55:0] bit_q;

	logic [64:0] rem_sh;
	logic        ge;
	logic [64:0] rem_sub;
	logic [56:0] trial;
	logic        take;

	always_comb begin
		rem_sh  = {rem_q, nq_q[63]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
		trial   = {1'b0, root_q} + {1'b0, bit_q};
		take    = {1'b0, sx_q} >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= sqrt_mode ? SQRT_STEPS : DIV_STEPS;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 7'd1;
				done_q <= (cnt_q == 7'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= sqrt_mode;
			rem_q  <= '0;
			nq_q   <= num;
			den_q  <= den;
			sx_q   <= num[55:0];
			root_q <= '0;
			bit_q  <= 56'h40000000000000;
		end else if (cnt_q != '0) begin
			if (mode_q) begin
				if (take) begin
					sx_q   <= sx_q - trial[55:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				// remainder stays below the divisor, so 64 bits hold it
				rem_q <= ge ? rem_sub[63:0] : rem_sh[63:0];
				nq_q  <= {nq_q[62:0], ge};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign done = done_q;
	assign res  = mode_q ? 64'(root_q) : nq_q;

endmodule

// ===== src/amsb_fifo.sv =====
// Two-entry queue of classified items between front and back.
// Depends on amsb_pkg for the item type.
module amsb_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  amsb_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output amsb_pkg::item_t pop_item,
	output logic            empty
);

	amsb_pkg::item_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_item;
	end

	assign pop_item = entry_q[rd_ptr_q];
	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);

endmodule

// ===== src/amsb_front.sv =====
// Front end: accepts items, advances step count and decay powers, classifies.
// Depends on amsb_pkg for the config and item types.
module amsb_front #(
	parameter int ELEMENT_COUNT = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  amsb_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [11:0]        element_index,
	input  logic signed [31:0] param_value,
	input  logic signed [31:0] grad_value,
	input  logic               pass_start,
	input  logic               q_full,
	input  logic               clearing,
	output logic               push,
	output amsb_pkg::item_t    push_item
);

	logic [31:0] step_q;
	logic [24:0] pow1_q;
	logic [24:0] pow2_q;

	logic [49:0] p1_prod, p2_prod;
	logic [49:0] p1_rnd, p2_rnd;
	logic [31:0] step_d;
	logic [24:0] pow1_d, pow2_d;

	assign in_stall = q_full | clearing;
	assign push     = in_valid & ~in_stall;

	always_comb begin
		p1_prod = 50'(pow1_q) * 50'(cfg.b1);
		p2_prod = 50'(pow2_q) * 50'(cfg.b2);
		p1_rnd  = p1_prod + 50'h800000;
		p2_rnd  = p2_prod + 50'h800000;
		step_d  = step_q;
		pow1_d  = pow1_q;
		pow2_d  = pow2_q;
		if (pass_start) begin
			if (step_q != 32'hFFFFFFFF) step_d = step_q + 32'd1;
			pow1_d = p1_rnd[48:24];
			pow2_d = p2_rnd[48:24];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			pow1_q <= amsb_pkg::ONE_Q;
			pow2_q <= amsb_pkg::ONE_Q;
		end else if (push) begin
			step_q <= step_d;
			pow1_q <= pow1_d;
			pow2_q <= pow2_d;
		end
	end

	always_comb begin
		push_item.idx    = element_index;
		push_item.param  = param_value;
		push_item.grad   = grad_value;
		push_item.step   = step_d;
		// a correction of zero counts as one LSB
		push_item.bc1    = (pow1_d < amsb_pkg::ONE_Q) ? amsb_pkg::ONE_Q - pow1_d : 25'd1;
		push_item.bc2    = (pow2_d < amsb_pkg::ONE_Q) ? amsb_pkg::ONE_Q - pow2_d : 25'd1;
		push_item.bypass = 21'(element_index) >= 21'(ELEMENT_COUNT);
	end

	a_step_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!push |=> $stable(step_q) && $stable(pow1_q) && $stable(pow2_q))
		else $error("step state changed without a transaction");
	a_step_inc: assert property (@(posedge clk) disable iff (!arst_n)
		push && pass_start && step_q != 32'hFFFFFFFF |=> step_q == $past(step_q) + 32'd1)
		else $error("step count did not advance on pass start");
	a_pow_range: assert property (@(posedge clk) disable iff (!arst_n)
		pow1_q <= amsb_pkg::ONE_Q && pow2_q <= amsb_pkg::ONE_Q)
		else $error("decay power above one");

endmodule

// ===== src/amsb_back.sv =====
// Back end: sequencer over the moment memories, shared multiplier and divide/root unit.
// Depends on amsb_pkg and amsb_divsqrt.
module amsb_back #(
	parameter int ELEMENT_COUNT = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  amsb_pkg::cfg_t     cfg,
	input  logic               q_empty,
	output logic               q_pop,
	input  amsb_pkg::item_t    q_item,
	output logic               clearing,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [11:0]        out_index,
	output logic signed [31:0] new_param
);

	localparam int ADDR_W = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;

	typedef enum logic [25:0] {
		S_CLR  = 26'h0000001,
		S_IDLE = 26'h0000002,
		S_RD   = 26'h0000004,
		S_M1   = 26'h0000008,
		S_M2   = 26'h0000010,
		S_M3   = 26'h0000020,
		S_M4   = 26'h0000040,
		S_M5   = 26'h0000080,
		S_M6   = 26'h0000100,
		S_M7   = 26'h0000200,
		S_M8   = 26'h0000400,
		S_DV1  = 26'h0000800,
		S_SQ   = 26'h0001000,
		S_DV2  = 26'h0002000,
		S_DV3  = 26'h0004000,
		S_LO   = 26'h0008000,
		S_LO2  = 26'h0010000,
		S_DV4  = 26'h0020000,
		S_UP1  = 26'h0040000,
		S_UP2  = 26'h0080000,
		S_UP3  = 26'h0100000,
		S_RATE = 26'h0200000,
		S_DV5  = 26'h0400000,
		S_UPD  = 26'h0800000,
		S_FIN  = 26'h1000000,
		S_EMIT = 26'h2000000
	} state_t;

	function automatic logic signed [66:0] rnd24(input logic signed [66:0] v);
		logic [66:0] mag;
		mag = v[66] ? 67'(-v) : 67'(v);
		mag = (mag + 67'h800000) >> 24;
		return v[66] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [31:0] satq(input logic signed [66:0] v);
		logic signed [31:0] r;
		r = v[31:0];
		if (v > 67'sh7FFFFFFF) r = 32'sh7FFFFFFF;
		else if (v < -67'sh80000000) r = -32'sh80000000;
		return r;
	endfunction

	function automatic logic [31:0] satu(input logic [66:0] v);
		return (v > 67'h7FFFFFFF) ? amsb_pkg::MAX_Q : v[31:0];
	endfunction

	state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              out_valid_q;

	amsb_pkg::item_t    item_q;
	logic signed [31:0] p_q, fac_q, m_q;
	logic [31:0]        gsq_q, pk_q, base_q, lower_q, upper_q, rate_q;
	logic signed [65:0] acc_q;
	logic [63:0]        gt_q;
	logic [24:0]        inv1_q;
	logic [48:0]        inv2_q;
	logic signed [32:0] mhat_q;
	logic [11:0]        out_index_q;
	logic signed [31:0] out_param_q;

	logic signed [31:0] mem_m [ELEMENT_COUNT];
	logic [31:0]        mem_v [ELEMENT_COUNT];
	logic [31:0]        mem_pk [ELEMENT_COUNT];
	logic signed [31:0] rd_m_q;
	logic [31:0]        rd_v_q, rd_pk_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_q;

	logic               div_start, div_sqrt, div_busy, div_done;
	logic [63:0]        div_num, div_den, div_res;

	logic               mem_we, mem_re;
	logic [ADDR_W-1:0]  mem_addr;
	logic signed [31:0] wr_m;
	logic [31:0]        wr_v, wr_pk;

	logic signed [32:0] g33, gmag;
	logic [65:0]        lw_rnd;
	logic signed [43:0] fac_d;
	logic signed [31:0] fac_new, m_new, p_wd, p_fin;
	logic [31:0]        gsq_new, v_new, pk_new, vhat, denom, mmag, mm_sat, upper_new;
	logic [31:0]        rate_lo, rate_new;
	logic [66:0]        v_sum, lower_sum;
	logic [81:0]        pbig, pbig_rnd;
	logic [63:0]        gt_one;
	logic               out_free;

	amsb_divsqrt u_divsqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.sqrt_mode (div_sqrt),
		.num       (div_num),
		.den       (div_den),
		.busy      (div_busy),
		.done      (div_done),
		.res       (div_res)
	);

	assign out_free = ~out_valid_q | ~out_stall;
	assign gt_one   = gt_q + 64'(amsb_pkg::ONE_Q);

	// datapath values consumed by the sequencer
	always_comb begin
		g33       = 33'(item_q.grad);
		gmag      = g33[32] ? -g33 : g33;
		lw_rnd    = unsigned'(mul_q) + 66'h800000;
		fac_d     = 44'sh1000000 - $signed({2'b00, lw_rnd[65:24]});
		fac_new   = (fac_d < -44'sh80000000) ? -32'sh80000000 : fac_d[31:0];
		m_new     = satq(rnd24(67'(acc_q) + 67'(mul_q)));
		p_wd      = satq(rnd24(67'(mul_q)));
		gsq_new   = satu(67'(unsigned'(mul_q)) + 67'h800000 >> 24);
		v_sum     = 67'(unsigned'(acc_q)) + 67'(unsigned'(mul_q)) + 67'h800000;
		v_new     = satu(v_sum >> 24);
		pk_new    = (v_new > rd_pk_q) ? v_new : rd_pk_q;
		vhat      = satu(67'(div_res));
		denom     = satu(67'(div_res) + 67'(cfg.eps));
		lower_sum = 67'(unsigned'(mul_q)) + 67'h800000;
		pbig      = 82'(unsigned'(acc_q)) + (82'(unsigned'(mul_q)) << 24);
		pbig_rnd  = (pbig + 82'h800000) >> 24;
		upper_new = (pbig > (82'(amsb_pkg::MAX_Q) << 24)) ? amsb_pkg::MAX_Q
			: satu(67'(cfg.fin) + 67'(pbig_rnd));
		rate_lo   = (base_q < lower_q) ? lower_q : base_q;
		rate_new  = (rate_lo > upper_q) ? upper_q : rate_lo;
		mmag      = m_q[31] ? 32'(-33'(m_q)) : 32'(m_q);
		mm_sat    = satu(67'(div_res));
		p_fin     = satq(67'(p_q) - rnd24(67'(mul_q)));
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_RD: begin mul_a = 33'(cfg.lr); mul_b = 33'(cfg.wd); end
			S_M1: begin mul_a = 33'(cfg.b1); mul_b = 33'(rd_m_q); end
			S_M2: begin mul_a = 33'(amsb_pkg::ONE_Q - cfg.b1); mul_b = g33; end
			S_M3: begin mul_a = 33'(p_q); mul_b = 33'(fac_q); end
			S_M4: begin mul_a = gmag; mul_b = gmag; end
			S_M5: begin mul_a = 33'(cfg.b2); mul_b = 33'(rd_v_q); end
			S_M6: begin mul_a = 33'(amsb_pkg::ONE_Q - cfg.b2); mul_b = 33'(gsq_q); end
			S_M7: begin mul_a = 33'(cfg.gam); mul_b = 33'(item_q.step); end
			S_LO: begin mul_a = 33'(cfg.fin); mul_b = 33'(amsb_pkg::ONE_Q - inv1_q); end
			S_UP1: begin mul_a = 33'(cfg.fin); mul_b = 33'(inv2_q[23:0]); end
			S_UP2: begin mul_a = 33'(cfg.fin); mul_b = 33'(inv2_q[48:24]); end
			S_UPD: begin mul_a = 33'(rate_q); mul_b = mhat_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// divide/root requests
	always_comb begin
		div_start = 1'b0;
		div_sqrt  = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			S_M8: begin
				div_start = 1'b1;
				div_num   = (64'(pk_q) << 24) + 64'(item_q.bc2 >> 1);
				div_den   = 64'(item_q.bc2);
			end
			S_DV1: begin
				div_start = div_done;
				div_sqrt  = 1'b1;
				div_num   = 64'(vhat) << 24;
			end
			S_SQ: begin
				// a zero divisor yields all ones, which saturates like the zero case
				div_start = div_done;
				div_num   = (64'(cfg.lr) << 24) + 64'(denom >> 1);
				div_den   = 64'(denom);
			end
			S_DV2: begin
				div_start = div_done;
				div_num   = 64'h1000000000000 + (gt_one >> 1);
				div_den   = gt_one;
			end
			S_LO2: begin
				div_start = (gt_q != '0);
				div_num   = 64'h1000000000000 + (gt_q >> 1);
				div_den   = gt_q;
			end
			S_RATE: begin
				div_start = 1'b1;
				div_num   = (64'(mmag) << 24) + 64'(item_q.bc1 >> 1);
				div_den   = 64'(item_q.bc1);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR:  if (clr_cnt_q == ADDR_W'(ELEMENT_COUNT - 1)) state_d = S_IDLE;
			S_IDLE: if (!q_empty) state_d = q_item.bypass ? S_EMIT : S_RD;
			S_RD:   state_d = S_M1;
			S_M1:   state_d = S_M2;
			S_M2:   state_d = S_M3;
			S_M3:   state_d = S_M4;
			S_M4:   state_d = S_M5;
			S_M5:   state_d = S_M6;
			S_M6:   state_d = S_M7;
			S_M7:   state_d = S_M8;
			S_M8:   state_d = S_DV1;
			S_DV1:  if (div_done) state_d = S_SQ;
			S_SQ:   if (div_done) state_d = S_DV2;
			S_DV2:  if (div_done) state_d = S_DV3;
			S_DV3:  if (div_done) state_d = S_LO;
			S_LO:   state_d = S_LO2;
			S_LO2:  state_d = (gt_q != '0) ? S_DV4 : S_RATE;
			S_DV4:  if (div_done) state_d = S_UP1;
			S_UP1:  state_d = S_UP2;
			S_UP2:  state_d = S_UP3;
			S_UP3:  state_d = S_RATE;
			S_RATE: state_d = S_DV5;
			S_DV5:  if (div_done) state_d = S_UPD;
			S_UPD:  state_d = S_FIN;
			S_FIN:  state_d = S_EMIT;
			S_EMIT: if (out_free) state_d = S_IDLE;
			default: state_d = S_CLR;
		endcase
	end

	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign clearing = (state_q == S_CLR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			if (state_q == S_EMIT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: if (!q_empty) begin
				item_q <= q_item;
				p_q    <= q_item.param;
			end
			S_M1: fac_q <= fac_new;
			S_M2: acc_q <= mul_q;
			S_M3: m_q <= m_new;
			S_M4: if (cfg.wd != '0) p_q <= p_wd;
			S_M5: gsq_q <= gsq_new;
			S_M6: acc_q <= mul_q;
			S_M7: pk_q <= pk_new;
			S_M8: gt_q <= unsigned'(mul_q[63:0]);
			S_DV2: if (div_done) base_q <= satu(67'(div_res));
			S_DV3: if (div_done) inv1_q <= div_res[24:0];
			S_LO2: begin
				lower_q <= lower_sum[55:24];
				if (gt_q == '0) upper_q <= amsb_pkg::MAX_Q;
			end
			S_DV4: if (div_done) inv2_q <= div_res[48:0];
			S_UP2: acc_q <= mul_q;
			S_UP3: upper_q <= upper_new;
			S_RATE: rate_q <= rate_new;
			S_DV5: if (div_done) mhat_q <= m_q[31] ? -33'(mm_sat) : 33'(mm_sat);
			S_FIN: p_q <= p_fin;
			S_EMIT: if (out_free) begin
				out_index_q <= item_q.idx;
				out_param_q <= p_q;
			end
			default: begin
			end
		endcase
	end

	// moment memories: one write and one registered read port each
	always_comb begin
		mem_re   = (state_q == S_RD);
		mem_we   = (state_q == S_CLR) || (state_q == S_M7);
		mem_addr = (state_q == S_CLR) ? clr_cnt_q : ADDR_W'(item_q.idx);
		wr_m     = (state_q == S_CLR) ? '0 : m_q;
		wr_v     = (state_q == S_CLR) ? '0 : v_new;
		wr_pk    = (state_q == S_CLR) ? '0 : pk_new;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_m[mem_addr]  <= wr_m;
			mem_v[mem_addr]  <= wr_v;
			mem_pk[mem_addr] <= wr_pk;
		end
		if (mem_re) begin
			rd_m_q  <= mem_m[mem_addr];
			rd_v_q  <= mem_v[mem_addr];
			rd_pk_q <= mem_pk[mem_addr];
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign new_param = out_param_q;

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divide unit started while busy");
	a_clr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !out_valid_q && !q_pop)
		else $error("activity during clearing pass");
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q == S_M7 |-> wr_pk >= wr_v)
		else $error("peak second moment below second moment");

endmodule

// ===== src/amsbound_param_update_top.sv =====
// AMSBound update: the back end works on one element at a time, with no overlap; its
// pace is set by the bit-serial divide/root unit (five 64-step divisions, one 28-step
// root). The upper division is skipped while gamma*t is zero.
// Out-of-range indices skip the update sequence and go straight to output. After reset
// a clearing pass zeroes all ELEMENT_COUNT entries of the moment memories; input stalls meanwhile.
// Holds the configuration registers; depends on amsb_pkg and all amsb_ modules.
module amsbound_param_update_top #(
	parameter int ELEMENT_COUNT = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [11:0]        element_index,
	input  logic signed [31:0] param_value,
	input  logic signed [31:0] grad_value,
	input  logic               pass_start,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [11:0]        out_index,
	output logic signed [31:0] new_param,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data
);

	logic [30:0] lr_q, fin_q, gam_q, eps_q, wd_q;
	logic [24:0] b1_q, b2_q;

	amsb_pkg::cfg_t  cfg;
	amsb_pkg::item_t push_item, pop_item;
	logic            push, pop, q_full, q_empty, clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= 31'd16777;
			b1_q  <= 25'd15099494;
			b2_q  <= 25'd16760439;
			fin_q <= 31'd1677722;
			gam_q <= 31'd16777;
			eps_q <= 31'd1;
			wd_q  <= 31'd0;
		end else if (cfg_wr_en) begin
			unique case (amsb_pkg::cfg_idx_t'(cfg_index))
				amsb_pkg::CFG_LEARNING_RATE: lr_q  <= cfg_data;
				amsb_pkg::CFG_FIRST_DECAY:   b1_q  <= cfg_data[24:0];
				amsb_pkg::CFG_SECOND_DECAY:  b2_q  <= cfg_data[24:0];
				amsb_pkg::CFG_TARGET_RATE:   fin_q <= cfg_data;
				amsb_pkg::CFG_BOUND_SPEED:   gam_q <= cfg_data;
				amsb_pkg::CFG_EPSILON:       eps_q <= cfg_data;
				amsb_pkg::CFG_DECAY_WEIGHT:  wd_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// decays above one act as one
	always_comb begin
		cfg.lr  = lr_q;
		cfg.b1  = (b1_q > amsb_pkg::ONE_Q) ? amsb_pkg::ONE_Q : b1_q;
		cfg.b2  = (b2_q > amsb_pkg::ONE_Q) ? amsb_pkg::ONE_Q : b2_q;
		cfg.fin = fin_q;
		cfg.gam = gam_q;
		cfg.eps = eps_q;
		cfg.wd  = wd_q;
	end

	amsb_front #(.ELEMENT_COUNT(ELEMENT_COUNT)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.element_index (element_index),
		.param_value   (param_value),
		.grad_value    (grad_value),
		.pass_start    (pass_start),
		.q_full        (q_full),
		.clearing      (clearing),
		.push          (push),
		.push_item     (push_item)
	);

	amsb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	amsb_back #(.ELEMENT_COUNT(ELEMENT_COUNT)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_pop     (pop),
		.q_item    (pop_item),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_index (out_index),
		.new_param (new_param)
	);

endmodule
